FILE: sv/pbem_pkg.sv
// ----------------------------------------------------------------------------
// pbem_pkg
// Shared types, constants and helper functions for the exact-match palette
// builder: register map, control states, gray mean and power-of-two rounding.
// ----------------------------------------------------------------------------
package pbem_pkg;

	localparam int unsigned CHAN_W  = 8;
	localparam int unsigned COLOR_W = 3 * CHAN_W;
	localparam int unsigned COUNT_W = 9;
	localparam int unsigned INDEX_W = 8;
	localparam int unsigned PADDR_W = 4;
	localparam int unsigned PDATA_W = 32;

	// reciprocal of three for a 10-bit dividend: floor(x * 683 / 2048)
	localparam int unsigned RECIP3   = 683;
	localparam int unsigned RECIP3_SH = 11;

	typedef logic [1:0] reg_sel_t;
	localparam reg_sel_t REG_BG_RED   = 2'd0;
	localparam reg_sel_t REG_BG_GREEN = 2'd1;
	localparam reg_sel_t REG_BG_BLUE  = 2'd2;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} pbem_state_t;

	function automatic logic [CHAN_W-1:0] gray_mean(
		input logic [CHAN_W-1:0] r,
		input logic [CHAN_W-1:0] g,
		input logic [CHAN_W-1:0] b
	);
		logic [9:0]  sum;
		logic [19:0] prod;
		sum  = {2'b00, r} + {2'b00, g} + {2'b00, b};
		prod = 20'(sum) * 20'(RECIP3);
		return prod[RECIP3_SH +: CHAN_W];
	endfunction

	function automatic logic [COUNT_W-1:0] round_pow2(input logic [COUNT_W-1:0] n);
		logic [COUNT_W:0] s;
		s = (COUNT_W+1)'(2);
		for (int i = 0; i < 8; i++) begin
			if (s < {1'b0, n}) begin
				s = s << 1;
			end
		end
		return s[COUNT_W-1:0];
	endfunction

endpackage

FILE: sv/pbem_regs.sv
// ----------------------------------------------------------------------------
// pbem_regs
// APB register block for the background colour; supplies the gray mean used
// to seed entry zero of the palette on a restart.
// ----------------------------------------------------------------------------
module pbem_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pbem_pkg::PADDR_W-1:0]  paddr,
	input  logic [pbem_pkg::PDATA_W-1:0]  pwdata,
	output logic [pbem_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	output logic [pbem_pkg::CHAN_W-1:0]   bg_gray
);
	import pbem_pkg::*;

	logic [CHAN_W-1:0] bg_red_q;
	logic [CHAN_W-1:0] bg_green_q;
	logic [CHAN_W-1:0] bg_blue_q;
	logic              wr_en;
	reg_sel_t          sel;

	assign pready = 1'b1;
	assign sel    = paddr[3:2];
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bg_red_q   <= '0;
			bg_green_q <= '0;
			bg_blue_q  <= '0;
		end else if (wr_en) begin
			case (sel)
				REG_BG_RED:   bg_red_q   <= pwdata[CHAN_W-1:0];
				REG_BG_GREEN: bg_green_q <= pwdata[CHAN_W-1:0];
				REG_BG_BLUE:  bg_blue_q  <= pwdata[CHAN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (sel)
			REG_BG_RED:   prdata = PDATA_W'(bg_red_q);
			REG_BG_GREEN: prdata = PDATA_W'(bg_green_q);
			REG_BG_BLUE:  prdata = PDATA_W'(bg_blue_q);
			default:      prdata = '0;
		endcase
	end

	assign bg_gray = gray_mean(bg_red_q, bg_green_q, bg_blue_q);

endmodule

FILE: sv/palette_builder_exact_match_unit.sv
// ----------------------------------------------------------------------------
// palette_builder_exact_match_unit
// Builds a table of distinct 24-bit colours by exact-match lookup over a
// synchronous memory, appending colours not yet present.
// ----------------------------------------------------------------------------
// Operation: an accepted pixel scans the table from entry zero, one entry per
//   cycle through the registered memory read, until it hits or reaches the
//   colour count; done is registered from the result. Busy is high during the
//   scan and start is ignored; once overflowed, non-first pixels skip the scan.
// Reset: count 1, overflow clear, control flops 0; table contents undefined
//   until the first pixel flagged first_pixel seeds entry zero. No clearing pass.
module palette_builder_exact_match_unit #(
	parameter int unsigned TABLE_DEPTH = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pbem_pkg::PADDR_W-1:0]  paddr,
	input  logic [pbem_pkg::PDATA_W-1:0]  pwdata,
	output logic [pbem_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	input  logic                          start,
	output logic                          busy,
	input  logic [pbem_pkg::CHAN_W-1:0]   red,
	input  logic [pbem_pkg::CHAN_W-1:0]   green,
	input  logic [pbem_pkg::CHAN_W-1:0]   blue,
	input  logic                          first_pixel,
	output logic                          done,
	output logic [pbem_pkg::INDEX_W-1:0]  color_index,
	output logic                          is_new,
	output logic                          overflow,
	output logic [pbem_pkg::COUNT_W-1:0]  color_count,
	output logic [pbem_pkg::COUNT_W-1:0]  table_size
);
	import pbem_pkg::*;

	localparam int unsigned ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam logic [COUNT_W-1:0] DEPTH_C = COUNT_W'(TABLE_DEPTH);

	logic [CHAN_W-1:0]  bg_gray;
	pbem_state_t        state_q, state_d;
	logic [COLOR_W-1:0] color_q;
	logic [COUNT_W-1:0] ptr_q;
	logic [COUNT_W-1:0] count_q;
	logic               ovf_q;
	logic               valid_s1;
	logic [ADDR_W-1:0]  addr_s1;
	logic [COLOR_W-1:0] rdata_s1;
	logic [COLOR_W-1:0] mem [TABLE_DEPTH];

	logic               acc, issue, hit, miss, room, fin;
	logic               mem_we;
	logic [ADDR_W-1:0]  mem_wa;
	logic [COLOR_W-1:0] mem_wd;
	logic [INDEX_W-1:0] res_index;
	logic               res_new, res_ovf;
	logic [COUNT_W-1:0] res_count;

	logic               done_q, is_new_q, overflow_q;
	logic [INDEX_W-1:0] color_index_q;
	logic [COUNT_W-1:0] color_count_q, table_size_q;

	pbem_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.bg_gray (bg_gray)
	);

	assign busy = (state_q == ST_SCAN);
	assign acc  = start && !busy;
	assign room = (count_q < DEPTH_C);

	always_comb begin
		state_d   = state_q;
		issue     = 1'b0;
		hit       = 1'b0;
		miss      = 1'b0;
		fin       = 1'b0;
		res_index = '0;
		res_new   = 1'b0;
		res_ovf   = ovf_q;
		res_count = count_q;
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					if (first_pixel || !ovf_q) begin
						state_d = ST_SCAN;
					end else begin
						fin = 1'b1;
					end
				end
			end
			ST_SCAN: begin
				hit   = valid_s1 && (rdata_s1 == color_q);
				miss  = !valid_s1 && (ptr_q == count_q);
				issue = !hit && (ptr_q < count_q);
				if (hit) begin
					fin       = 1'b1;
					res_index = INDEX_W'(addr_s1);
					state_d   = ST_IDLE;
				end else if (miss) begin
					fin     = 1'b1;
					state_d = ST_IDLE;
					if (room) begin
						res_index = INDEX_W'(count_q[ADDR_W-1:0]);
						res_new   = 1'b1;
						res_count = count_q + COUNT_W'(1);
					end else begin
						res_ovf = 1'b1;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign mem_we = (acc && first_pixel) || (miss && room);
	assign mem_wa = acc ? '0 : count_q[ADDR_W-1:0];
	assign mem_wd = acc ? {bg_gray, bg_gray, bg_gray} : color_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rdata_s1 <= mem[ptr_q[ADDR_W-1:0]];
		addr_s1  <= ptr_q[ADDR_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ptr_q    <= '0;
			count_q  <= COUNT_W'(1);
			ovf_q    <= 1'b0;
			valid_s1 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			valid_s1 <= issue;
			done_q   <= fin;
			if (acc) begin
				ptr_q <= '0;
				if (first_pixel) begin
					count_q <= COUNT_W'(1);
					ovf_q   <= 1'b0;
				end
			end else begin
				if (issue) begin
					ptr_q <= ptr_q + COUNT_W'(1);
				end
				if (fin) begin
					count_q <= res_count;
					ovf_q   <= res_ovf;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		color_q <= acc ? {red, green, blue} : color_q;
		if (fin) begin
			color_index_q <= res_index;
			is_new_q      <= res_new;
			overflow_q    <= res_ovf;
			color_count_q <= res_count;
			table_size_q  <= round_pow2(res_count);
		end
	end

	assign done        = done_q;
	assign color_index = color_index_q;
	assign is_new      = is_new_q;
	assign overflow    = overflow_q;
	assign color_count = color_count_q;
	assign table_size  = table_size_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= COUNT_W'(1)) && (count_q <= DEPTH_C))
		else $error("colour count out of range");

	a_ptr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (ptr_q <= count_q))
		else $error("scan pointer beyond colour count");

	a_new_index: assert property (@(posedge clk) disable iff (!arst_n)
		(done && is_new) |-> (color_index == INDEX_W'(color_count - COUNT_W'(1))))
		else $error("appended index does not match colour count");

	a_ovf_result: assert property (@(posedge clk) disable iff (!arst_n)
		(done && overflow) |-> ((color_index == '0) && !is_new))
		else $error("overflowed result carries an index");

	a_size_covers: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (table_size >= color_count))
		else $error("table size below colour count");

endmodule
